>>> src/dwpu_pkg.sv
// Shared constants, types and helpers for the display window pixel unpacker.
`timescale 1ns / 1ps
package dwpu_pkg;

    localparam int VRAM_WIDTH  = 1024;
    localparam int VRAM_HEIGHT = 512;
    localparam int MAX_W_LIMIT = (VRAM_WIDTH < 1024) ? VRAM_WIDTH : 1024;
    localparam int MAX_H_LIMIT = (VRAM_HEIGHT < 512) ? VRAM_HEIGHT : 512;

    localparam int WORD_BITS     = 16;
    localparam int CHAN_BITS     = 8;
    localparam int W_BITS        = 11;
    localparam int H_BITS        = 10;
    localparam int COL_BITS      = 11;
    localparam int LINE_BITS     = 9;
    localparam int COUNT_BITS    = 20;
    localparam int AREA_BITS     = 20;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 11;
    localparam int FIFO_DEPTH    = 4;

    // Power-on register values
    localparam logic [W_BITS-1:0] WIDTH_RESET  = 11'd320;
    localparam logic [H_BITS-1:0] HEIGHT_RESET = 10'd240;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_DEEP   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
        logic                 frame_end;
    } t_pixel;

    typedef struct packed {
        logic                 restart;
        logic [AREA_BITS-1:0] area;
    } t_ctl;

    function automatic logic [CHAN_BITS-1:0] widen5(input logic [4:0] v);
        widen5 = {v, v[4:2]};
    endfunction

endpackage

>>> src/dwpu_word_if.sv
// Input channel carrying one video memory word per transfer.
`timescale 1ns / 1ps
interface dwpu_word_if;
    logic                           valid;
    logic                           ready;
    logic [dwpu_pkg::WORD_BITS-1:0] vram_word;

    modport source (output valid, output vram_word, input ready);
    modport sink   (input valid, input vram_word, output ready);
endinterface

>>> src/dwpu_pix_if.sv
// Output channel carrying one RGB888 pixel per transfer.
`timescale 1ns / 1ps
interface dwpu_pix_if;
    logic                           valid;
    logic                           ready;
    logic [dwpu_pkg::CHAN_BITS-1:0] red;
    logic [dwpu_pkg::CHAN_BITS-1:0] green;
    logic [dwpu_pkg::CHAN_BITS-1:0] blue;
    logic                           frame_end;
    logic                           has_content;

    modport source (output valid, output red, output green, output blue,
                    output frame_end, output has_content, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input frame_end, input has_content, output ready);
endinterface

>>> src/dwpu_fifo.sv
// Small pixel queue between the unpacking front end and the counting back end.
`timescale 1ns / 1ps
module dwpu_fifo #(
    parameter int DEPTH = dwpu_pkg::FIFO_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  dwpu_pkg::t_pixel      i_data,
    input  logic                  i_pop,
    output dwpu_pkg::t_pixel      o_data,
    output logic                  o_empty,
    output logic                  o_full,
    output logic [$clog2(DEPTH):0] o_level
);
    localparam int PTR_W = $clog2(DEPTH);

    dwpu_pkg::t_pixel r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_level;
    logic             w_push;
    logic             w_pop;

    assign o_empty = (r_level == '0);
    assign o_full  = (r_level == (PTR_W+1)'(DEPTH));
    assign o_level = r_level;
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            unique case ({w_push, w_pop})
                2'b10:   r_level <= r_level + (PTR_W+1)'(1);
                2'b01:   r_level <= r_level - (PTR_W+1)'(1);
                default: r_level <= r_level;
            endcase
        end
    end
endmodule

>>> src/dwpu_front.sv
// Front end: configuration registers, raster position and word-to-pixel unpacking.
`timescale 1ns / 1ps
module dwpu_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dwpu_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [dwpu_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    dwpu_word_if.sink                           i_in,
    input  logic                                i_fifo_full,
    output logic                                o_push,
    output dwpu_pkg::t_pixel                    o_pix,
    output dwpu_pkg::t_ctl                      o_ctl
);
    localparam int W  = dwpu_pkg::W_BITS;
    localparam int H  = dwpu_pkg::H_BITS;
    localparam int CB = dwpu_pkg::COL_BITS;
    localparam int LB = dwpu_pkg::LINE_BITS;
    localparam int AB = dwpu_pkg::AREA_BITS;

    logic [W-1:0]  r_width_pixels;
    logic [H-1:0]  r_height_lines;
    logic          r_deep_color;
    logic [CB-1:0] r_word_column;
    logic [LB-1:0] r_line_index;
    logic [1:0]    r_byte_phase;
    logic [15:0]   r_held_bytes;
    logic [AB-1:0] r_area;

    logic [CB-1:0] n_word_column;
    logic [LB-1:0] n_line_index;
    logic [1:0]    n_byte_phase;
    logic [15:0]   n_held_bytes;

    logic          w_restart;
    logic          w_accept;
    logic [W-1:0]  w_eff_w;
    logic [H-1:0]  w_eff_h;
    logic [W:0]    w_w3p1;
    logic [CB-1:0] w_row_words;
    logic          w_row_last;
    logic          w_frame_last;
    logic [AB-1:0] w_area_full;
    logic          w_have;
    logic [7:0]    w_lo;
    logic [7:0]    w_hi;
    logic [7:0]    w_red;
    logic [7:0]    w_green;
    logic [7:0]    w_blue;

    always_comb begin
        w_restart = 1'b0;
        if (i_cfg_we) begin
            unique case (dwpu_pkg::t_cfg_idx'(i_cfg_index))
                dwpu_pkg::CFG_WIDTH,
                dwpu_pkg::CFG_HEIGHT,
                dwpu_pkg::CFG_DEEP: w_restart = 1'b1;
                default:            w_restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_pixels <= dwpu_pkg::WIDTH_RESET;
            r_height_lines <= dwpu_pkg::HEIGHT_RESET;
            r_deep_color   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (dwpu_pkg::t_cfg_idx'(i_cfg_index))
                dwpu_pkg::CFG_WIDTH:  r_width_pixels <= i_cfg_data[W-1:0];
                dwpu_pkg::CFG_HEIGHT: r_height_lines <= i_cfg_data[H-1:0];
                dwpu_pkg::CFG_DEEP:   r_deep_color   <= i_cfg_data[0];
                default:              ;
            endcase
        end
    end

    // Clamp the window size to the supported range
    always_comb begin
        if (r_width_pixels == '0) begin
            w_eff_w = W'(1);
        end else if (r_width_pixels > W'(dwpu_pkg::MAX_W_LIMIT)) begin
            w_eff_w = W'(dwpu_pkg::MAX_W_LIMIT);
        end else begin
            w_eff_w = r_width_pixels;
        end
        if (r_height_lines == '0) begin
            w_eff_h = H'(1);
        end else if (r_height_lines > H'(dwpu_pkg::MAX_H_LIMIT)) begin
            w_eff_h = H'(dwpu_pkg::MAX_H_LIMIT);
        end else begin
            w_eff_h = r_height_lines;
        end
    end

    // Packed 24-bit rows take (3*width+1)/2 words
    assign w_w3p1       = {w_eff_w, 1'b0} + (W+1)'(w_eff_w) + (W+1)'(1);
    assign w_row_words  = r_deep_color ? CB'(w_w3p1[W:1]) : CB'(w_eff_w);
    assign w_row_last   = ((CB+1)'(r_word_column) + (CB+1)'(1)) >= (CB+1)'(w_row_words);
    assign w_frame_last = w_row_last
                       && (((H+1)'(r_line_index) + (H+1)'(1)) >= (H+1)'(w_eff_h));
    // clamped width times clamped height never exceeds 2^19
    assign w_area_full  = AB'(w_eff_w) * AB'(w_eff_h);

    assign w_lo = i_in.vram_word[7:0];
    assign w_hi = i_in.vram_word[15:8];

    always_comb begin
        w_have       = 1'b0;
        w_red        = '0;
        w_green      = '0;
        w_blue       = '0;
        n_byte_phase = r_byte_phase;
        n_held_bytes = r_held_bytes;
        if (!r_deep_color) begin
            w_red   = dwpu_pkg::widen5(i_in.vram_word[4:0]);
            w_green = dwpu_pkg::widen5(i_in.vram_word[9:5]);
            w_blue  = dwpu_pkg::widen5(i_in.vram_word[14:10]);
            w_have  = 1'b1;
        end else begin
            priority case (r_byte_phase)
                2'd1: begin
                    w_red        = r_held_bytes[7:0];
                    w_green      = w_lo;
                    w_blue       = w_hi;
                    n_held_bytes = '0;
                    n_byte_phase = 2'd0;
                    w_have       = 1'b1;
                end
                2'd2: begin
                    w_red        = r_held_bytes[7:0];
                    w_green      = r_held_bytes[15:8];
                    w_blue       = w_lo;
                    n_held_bytes = {8'd0, w_hi};
                    n_byte_phase = 2'd1;
                    w_have       = 1'b1;
                end
                default: begin
                    n_held_bytes = i_in.vram_word;
                    n_byte_phase = 2'd2;
                end
            endcase
            // drop the spare byte of an odd-width row
            if (w_row_last) begin
                n_held_bytes = '0;
                n_byte_phase = 2'd0;
            end
        end
    end

    always_comb begin
        n_word_column = r_word_column + CB'(1);
        n_line_index  = r_line_index;
        if (w_row_last) begin
            n_word_column = '0;
            n_line_index  = w_frame_last ? '0 : r_line_index + LB'(1);
        end
    end

    assign i_in.ready = !i_fifo_full;
    assign w_accept   = i_in.valid && !i_fifo_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_column <= '0;
            r_line_index  <= '0;
            r_byte_phase  <= '0;
            r_held_bytes  <= '0;
        end else if (w_restart) begin
            r_word_column <= '0;
            r_line_index  <= '0;
            r_byte_phase  <= '0;
            r_held_bytes  <= '0;
        end else if (w_accept) begin
            r_word_column <= n_word_column;
            r_line_index  <= n_line_index;
            r_byte_phase  <= n_byte_phase;
            r_held_bytes  <= n_held_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        r_area <= w_area_full;
    end

    assign o_push          = w_accept && w_have;
    assign o_pix.red       = w_red;
    assign o_pix.green     = w_green;
    assign o_pix.blue      = w_blue;
    assign o_pix.frame_end = w_frame_last;
    assign o_ctl.restart   = w_restart;
    assign o_ctl.area      = r_area;
endmodule

>>> src/dwpu_back.sv
// Back end: non-black pixel count, content flag and the output register.
`timescale 1ns / 1ps
module dwpu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dwpu_pkg::t_ctl   i_ctl,
    input  logic             i_empty,
    input  dwpu_pkg::t_pixel i_pix,
    output logic             o_pop,
    dwpu_pix_if.source       o_pix
);
    localparam int CNT = dwpu_pkg::COUNT_BITS;
    localparam int PB  = CNT + 5;

    logic [CNT-1:0] r_count;
    logic           r_valid;
    logic [7:0]     r_red;
    logic [7:0]     r_green;
    logic [7:0]     r_blue;
    logic           r_frame_end;
    logic           r_has_content;

    logic [CNT-1:0] n_count;
    logic           w_nonblack;
    logic [PB-1:0]  w_count_x20;
    logic           w_content;

    assign o_pop      = !i_empty && (!r_valid || o_pix.ready);
    assign w_nonblack = |{i_pix.red, i_pix.green, i_pix.blue};
    assign n_count    = r_count + CNT'(w_nonblack);
    // count > area/20 exactly when 20*count > area
    assign w_count_x20 = {n_count, 4'd0} + PB'({n_count, 2'd0});
    assign w_content   = w_count_x20 > PB'(i_ctl.area);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_ctl.restart) begin
                r_count <= '0;
            end else if (o_pop) begin
                r_count <= i_pix.frame_end ? '0 : n_count;
            end
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_red         <= i_pix.red;
            r_green       <= i_pix.green;
            r_blue        <= i_pix.blue;
            r_frame_end   <= i_pix.frame_end;
            r_has_content <= i_pix.frame_end && w_content;
        end
    end

    assign o_pix.valid       = r_valid;
    assign o_pix.red         = r_red;
    assign o_pix.green       = r_green;
    assign o_pix.blue        = r_blue;
    assign o_pix.frame_end   = r_frame_end;
    assign o_pix.has_content = r_has_content;
endmodule

>>> src/display_window_pixel_unpacker.sv
// Top level of the display window pixel unpacker.
`timescale 1ns / 1ps
// Takes one 16-bit video memory word of the display window per clock, in raster
// order, and returns RGB888 pixels: one per word in 15-bit mode, and in packed
// 24-bit mode one per three bytes (a word that completes no pixel gives none,
// and the spare byte at the end of an odd-width row is dropped). The sustained
// rate is one word per clock while the pixel queue is not full, as the front end
// updates its position and byte phase for each word taken. A small queue of
// FIFO_DEPTH pixels separates the unpacking front end from the counting back end
// and its output register, through which each pixel passes, so output stalls back
// up into the input only once the queue is full. frame_end marks the frame's last
// pixel and then has_content is 1 when more than width*height/20 pixels were
// non-black. Any register write restarts the frame; write only while idle.
module display_window_pixel_unpacker #(
    parameter int FIFO_DEPTH = dwpu_pkg::FIFO_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [dwpu_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [dwpu_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    dwpu_word_if.sink                           i_in,
    dwpu_pix_if.source                          o_pix
);
    logic                         w_push;
    logic                         w_pop;
    logic                         w_empty;
    logic                         w_full;
    logic [$clog2(FIFO_DEPTH):0]  w_level;
    dwpu_pkg::t_pixel             w_front_pix;
    dwpu_pkg::t_pixel             w_head_pix;
    dwpu_pkg::t_ctl               w_ctl;

    dwpu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_fifo_full (w_full),
        .o_push      (w_push),
        .o_pix       (w_front_pix),
        .o_ctl       (w_ctl)
    );

    dwpu_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_pix),
        .i_pop   (w_pop),
        .o_data  (w_head_pix),
        .o_empty (w_empty),
        .o_full  (w_full),
        .o_level (w_level)
    );

    dwpu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_empty (w_empty),
        .i_pix   (w_head_pix),
        .o_pop   (w_pop),
        .o_pix   (o_pix)
    );

`ifndef NO_ASSERTIONS
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= ($clog2(FIFO_DEPTH)+1)'(FIFO_DEPTH))
        else $error("pixel queue level exceeds its depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("pixel pushed into a full queue");

    a_content_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.has_content) |-> o_pix.frame_end)
        else $error("content flag outside the frame's last pixel");

    a_pop_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_pix.valid)
        else $error("popped pixel did not reach the output register");
`endif
endmodule
